@@ sv/sha256h_pkg.sv @@
// ----------------------------------------------------------------------------
// sha256h_pkg
// Shared constants, types and round functions of the SHA-256 byte hasher.
// ----------------------------------------------------------------------------
package sha256h_pkg;

  // block geometry
  localparam int unsigned BLOCK_BYTES = 64;
  localparam int unsigned BLOCK_WORDS = BLOCK_BYTES / 4;
  localparam int unsigned FILL_W      = $clog2(BLOCK_BYTES);
  localparam int unsigned WIDX_W      = $clog2(BLOCK_WORDS);
  localparam int unsigned ROUNDS      = 64;
  localparam int unsigned RND_W       = $clog2(ROUNDS);
  localparam int unsigned DIGEST_WORDS = 8;
  localparam int unsigned DIDX_W      = $clog2(DIGEST_WORDS);
  localparam int unsigned LEN_W       = 64;
  // block count: the bit total is a multiple of the block size in bits
  localparam int unsigned BLK_CNT_W   = LEN_W - FILL_W - 3;

  // padding
  localparam logic [7:0]        PAD_BYTE  = 8'h80;
  localparam logic [FILL_W-1:0] LEN_START = FILL_W'(56);

  // round constants
  localparam logic [31:0] ROUND_K [ROUNDS] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  // initial hash values
  localparam logic [31:0] INIT_H [DIGEST_WORDS] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  // controller to datapath commands
  typedef struct packed {
    logic wr_byte;      // store the incoming byte, advance fill
    logic start;        // load working words from chain, clear round count
    logic round;        // one compression round
    logic final_add;    // fold working words into chain
    logic pad;          // overwrite block with padding
    logic pad_zero;     // padding block holds no message bytes
    logic pad_len;      // padding block carries the length
    logic load_digest;  // copy chain into output buffer
    logic clear;        // back to initial chain, fill and count
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic fill_last;    // the next byte completes the block
    logic fill_fits;    // pending bytes leave room for the length
    logic round_last;   // final round of the block
    logic out_busy;     // digest words still waiting
  } sts_t;

  function automatic logic [31:0] ror32(input logic [31:0] x, input int unsigned n);
    ror32 = (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] big_sig0(input logic [31:0] x);
    big_sig0 = ror32(x, 2) ^ ror32(x, 13) ^ ror32(x, 22);
  endfunction

  function automatic logic [31:0] big_sig1(input logic [31:0] x);
    big_sig1 = ror32(x, 6) ^ ror32(x, 11) ^ ror32(x, 25);
  endfunction

  function automatic logic [31:0] sml_sig0(input logic [31:0] x);
    sml_sig0 = ror32(x, 7) ^ ror32(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] sml_sig1(input logic [31:0] x);
    sml_sig1 = ror32(x, 17) ^ ror32(x, 19) ^ (x >> 10);
  endfunction

endpackage

@@ sv/sha256h_if.sv @@
// ----------------------------------------------------------------------------
// sha256h channel interfaces
// Valid/ready channels for message bytes in and digest words out.
// ----------------------------------------------------------------------------
interface sha256h_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] msg_byte;
  logic       byte_present;
  logic       end_of_message;

  modport source (output valid, output msg_byte, output byte_present,
                  output end_of_message, input ready);
  modport sink   (input valid, input msg_byte, input byte_present,
                  input end_of_message, output ready);
endinterface

interface sha256h_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_number;
  logic        last_word;

  modport source (output valid, output digest_word, output word_number,
                  output last_word, input ready);
  modport sink   (input valid, input digest_word, input word_number,
                  input last_word, output ready);
endinterface

@@ sv/sha256h_ctrl.sv @@
// ----------------------------------------------------------------------------
// sha256h_ctrl
// Sequencer: byte intake, padding, compression rounds and digest hand-off.
// ----------------------------------------------------------------------------
module sha256h_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               byte_present,
  input  logic               end_of_message,
  output logic               in_ready,
  input  sha256h_pkg::sts_t  sts,
  output sha256h_pkg::cmd_t  cmd
);
  import sha256h_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_PAD    = 6'b000010,
    S_ROUND  = 6'b000100,
    S_FINAL  = 6'b001000,
    S_PAD2   = 6'b010000,
    S_DIGEST = 6'b100000
  } state_t;

  state_t state, state_next;
  logic   end_pend, end_pend_next;     // data block compressing, message already ended
  logic   need_pad2, need_pad2_next;   // length goes into a further block
  logic   is_last, is_last_next;       // block being compressed closes the message
  logic   accept;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;

  // next state and commands
  always_comb begin
    state_next     = state;
    end_pend_next  = end_pend;
    need_pad2_next = need_pad2;
    is_last_next   = is_last;
    cmd            = '0;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (byte_present) begin
            cmd.wr_byte = 1'b1;
            if (sts.fill_last) begin
              cmd.start      = 1'b1;
              end_pend_next  = end_of_message;
              need_pad2_next = 1'b0;
              is_last_next   = 1'b0;
              state_next     = S_ROUND;
            end else if (end_of_message) begin
              state_next = S_PAD;
            end
          end else if (end_of_message) begin
            state_next = S_PAD;
          end
        end
      end
      S_PAD: begin
        cmd.pad        = 1'b1;
        cmd.pad_len    = sts.fill_fits;
        cmd.start      = 1'b1;
        end_pend_next  = 1'b0;
        need_pad2_next = !sts.fill_fits;
        is_last_next   = sts.fill_fits;
        state_next     = S_ROUND;
      end
      S_ROUND: begin
        cmd.round = 1'b1;
        if (sts.round_last) begin
          state_next = S_FINAL;
        end
      end
      S_FINAL: begin
        cmd.final_add = 1'b1;
        if (end_pend) begin
          state_next = S_PAD;
        end else if (need_pad2) begin
          state_next = S_PAD2;
        end else if (is_last) begin
          state_next = S_DIGEST;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_PAD2: begin
        cmd.pad        = 1'b1;
        cmd.pad_zero   = 1'b1;
        cmd.pad_len    = 1'b1;
        cmd.start      = 1'b1;
        need_pad2_next = 1'b0;
        is_last_next   = 1'b1;
        state_next     = S_ROUND;
      end
      S_DIGEST: begin
        if (!sts.out_busy) begin
          cmd.load_digest = 1'b1;
          cmd.clear       = 1'b1;
          state_next      = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      end_pend  <= 1'b0;
      need_pad2 <= 1'b0;
      is_last   <= 1'b0;
    end else begin
      state     <= state_next;
      end_pend  <= end_pend_next;
      need_pad2 <= need_pad2_next;
      is_last   <= is_last_next;
    end
  end

endmodule

@@ sv/sha256h_dp.sv @@
// ----------------------------------------------------------------------------
// sha256h_dp
// Block buffer and schedule window, round logic, chain words and digest out.
// ----------------------------------------------------------------------------
module sha256h_dp (
  input  logic                clk,
  input  logic                rst,
  input  logic [7:0]          msg_byte,
  input  sha256h_pkg::cmd_t   cmd,
  output sha256h_pkg::sts_t   sts,
  sha256h_out_if.source       out_ch
);
  import sha256h_pkg::*;

  logic [31:0]          blk_buf [BLOCK_WORDS];   // block bytes, then schedule window
  logic [FILL_W-1:0]    fill;
  logic [BLK_CNT_W-1:0] blk_cnt;
  logic [31:0]          chain [DIGEST_WORDS];
  logic [31:0]          wv [DIGEST_WORDS];        // working words a..h
  logic [RND_W-1:0]     rnd;
  logic [31:0]          dg [DIGEST_WORDS];
  logic [DIDX_W-1:0]    out_cnt;
  logic                 out_busy;

  logic [31:0]          t1, t2, sched_new;
  logic [31:0]          pad_words [BLOCK_WORDS];
  logic [LEN_W-1:0]     len_bits;
  logic                 out_take;

  // status to controller
  assign sts.fill_last  = (fill == '1);
  assign sts.fill_fits  = (fill < LEN_START);
  assign sts.round_last = (rnd == '1);
  assign sts.out_busy   = out_busy;

  // one compression round and the next schedule word
  always_comb begin
    t1 = wv[7] + big_sig1(wv[4]) + ((wv[4] & wv[5]) ^ (~wv[4] & wv[6]))
       + ROUND_K[rnd] + blk_buf[0];
    t2 = big_sig0(wv[0]) + ((wv[0] & wv[1]) ^ (wv[0] & wv[2]) ^ (wv[1] & wv[2]));
    sched_new = sml_sig1(blk_buf[14]) + blk_buf[9] + sml_sig0(blk_buf[1]) + blk_buf[0];
  end

  // message length in bits: whole blocks plus pending bytes
  assign len_bits = {blk_cnt, fill, 3'b000};

  // padded block: keep bytes below fill, marker at fill, zeros above, or all zeros
  always_comb begin
    logic [FILL_W-1:0] idx;
    idx = '0;
    for (int j = 0; j < BLOCK_WORDS; j++) begin
      for (int l = 0; l < 4; l++) begin
        idx = FILL_W'(j * 4 + l);
        if (cmd.pad_zero || idx > fill) begin
          pad_words[j][31-8*l -: 8] = 8'h00;
        end else if (idx == fill) begin
          pad_words[j][31-8*l -: 8] = PAD_BYTE;
        end else begin
          pad_words[j][31-8*l -: 8] = blk_buf[j][31-8*l -: 8];
        end
      end
    end
    if (cmd.pad_len) begin
      pad_words[BLOCK_WORDS-2] = len_bits[LEN_W-1:32];
      pad_words[BLOCK_WORDS-1] = len_bits[31:0];
    end
  end

  // block buffer, working words and round count
  always_ff @(posedge clk) begin
    if (cmd.wr_byte) begin
      blk_buf[fill[FILL_W-1:2]][8*(3-fill[1:0]) +: 8] <= msg_byte;
    end else if (cmd.pad) begin
      blk_buf <= pad_words;
    end else if (cmd.round) begin
      for (int i = 0; i < BLOCK_WORDS - 1; i++) begin
        blk_buf[i] <= blk_buf[i+1];
      end
      blk_buf[BLOCK_WORDS-1] <= sched_new;
    end
    if (cmd.start) begin
      wv  <= chain;
      rnd <= '0;
    end else if (cmd.round) begin
      wv[7] <= wv[6];
      wv[6] <= wv[5];
      wv[5] <= wv[4];
      wv[4] <= wv[3] + t1;
      wv[3] <= wv[2];
      wv[2] <= wv[1];
      wv[1] <= wv[0];
      wv[0] <= t1 + t2;
      rnd   <= rnd + 1'b1;
    end
  end

  // chain words, fill and block count
  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      chain   <= INIT_H;
      fill    <= '0;
      blk_cnt <= '0;
    end else begin
      if (cmd.final_add) begin
        for (int i = 0; i < DIGEST_WORDS; i++) begin
          chain[i] <= chain[i] + wv[i];
        end
      end
      if (cmd.wr_byte) begin
        fill <= fill + 1'b1;
        if (fill == '1) begin
          blk_cnt <= blk_cnt + 1'b1;
        end
      end
    end
  end

  // digest output buffer
  assign out_take = out_busy && out_ch.ready;

  always_ff @(posedge clk) begin
    if (cmd.load_digest) begin
      dg      <= chain;
      out_cnt <= '0;
    end else if (out_take) begin
      for (int i = 0; i < DIGEST_WORDS - 1; i++) begin
        dg[i] <= dg[i+1];
      end
      out_cnt <= out_cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_busy <= 1'b0;
    end else if (cmd.load_digest) begin
      out_busy <= 1'b1;
    end else if (out_take && out_cnt == '1) begin
      out_busy <= 1'b0;
    end
  end

  assign out_ch.valid       = out_busy;
  assign out_ch.digest_word = dg[0];
  assign out_ch.word_number = out_cnt;
  assign out_ch.last_word   = (out_cnt == '1);

endmodule

@@ sv/sha256_byte_stream_hasher.sv @@
// ----------------------------------------------------------------------------
// sha256_byte_stream_hasher
// SHA-256 over a byte stream, digest given out as eight 32-bit words.
// ----------------------------------------------------------------------------
// in_ch request: one message byte (byte_present) and/or end_of_message; a
//   request with neither is dropped. end_of_message alone closes the message
//   with the bytes already taken, so an empty message is allowed.
// out_ch request: one digest word, word_number 0 first, last_word on word 7.
// A byte that does not fill the block leaves the sequencer idle. The 64th byte
//   of a block starts the compression: 64 rounds, one per cycle, then the
//   chain update; no further byte is taken until it ends.
// End of message: a padding step and a compression, twice when 56 or more
//   bytes are pending, then the digest buffer is loaded; the first word is
//   valid on the next cycle.
// The digest sits in its own buffer, so a new message may stream in while the
//   words drain; the next digest is loaded only once the buffer is empty.
// in_ch.ready is low while a block is padded or compressed or a digest waits to load.
// Reset (rst, synchronous) restores the initial hash, empties the block and
//   drops any digest words not yet taken. A stalled receiver holds the
//   current word stable until it is taken.
// ----------------------------------------------------------------------------
module sha256_byte_stream_hasher (
  input  logic          clk,
  input  logic          rst,
  sha256h_in_if.sink    in_ch,
  sha256h_out_if.source out_ch
);
  import sha256h_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // sequencer
  sha256h_ctrl u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_ch.valid),
    .byte_present   (in_ch.byte_present),
    .end_of_message (in_ch.end_of_message),
    .in_ready       (in_ch.ready),
    .sts            (sts),
    .cmd            (cmd)
  );

  // hashing datapath
  sha256h_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .msg_byte (in_ch.msg_byte),
    .cmd      (cmd),
    .sts      (sts),
    .out_ch   (out_ch)
  );

endmodule

@@ test/sha256_byte_stream_hasher_tb.sv @@
// ----------------------------------------------------------------------------
// sha256_byte_stream_hasher_tb
// Sends byte requests in random bursts against a stalling digest receiver.
// Every digest word is checked against a SHA-256 computed inside the bench.
// ----------------------------------------------------------------------------
module sha256_byte_stream_hasher_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned REPORT_MAX   = 10;
  localparam int unsigned LONG_HOLD    = 400;
  localparam int unsigned DRAIN_CYCLES = 150;
  localparam int unsigned ITEM_TARGET  = 110;

  // sha-256 round constants and initial hash
  localparam logic [31:0] SHA_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };
  localparam logic [31:0] SHA_IV [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  typedef struct packed {
    logic [7:0] msg_byte;
    logic       byte_present;
    logic       end_of_message;
  } byte_req_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_number;
    logic        last_word;
  } digest_word_t;

  logic clk;
  logic rst;

  sha256h_in_if  in_bus ();
  sha256h_out_if out_bus ();

  sha256_byte_stream_hasher uut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_bus),
    .out_ch (out_bus)
  );

  // hashing state of the bench model
  logic [31:0] hash_state [8];
  logic [7:0]  blk_buf [64];
  int unsigned blk_fill;
  logic [63:0] hashed_bits;

  byte_req_t    byte_requests [$];
  digest_word_t digest_queue [$];

  int unsigned fault_count;
  int unsigned cycle_count;
  int unsigned burst_left;
  int unsigned gap_left;
  int unsigned words_taken;
  int unsigned hold_left;
  logic        hold_done;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    logic [63:0] twice;
    twice = {x, x} >> n;
    return twice[31:0];
  endfunction

  // one 64-round compression of blk_buf into hash_state
  function automatic void compress_buffer();
    logic [31:0] sched [64];
    logic [31:0] a, b, c, d, e, f, g, h, t1, t2;
    for (int r = 0; r < 16; r++) begin
      sched[r] = {blk_buf[4*r], blk_buf[4*r+1], blk_buf[4*r+2], blk_buf[4*r+3]};
    end
    for (int r = 16; r < 64; r++) begin
      sched[r] = (rotr(sched[r-2], 17) ^ rotr(sched[r-2], 19) ^ (sched[r-2] >> 10))
               + sched[r-7]
               + (rotr(sched[r-15], 7) ^ rotr(sched[r-15], 18) ^ (sched[r-15] >> 3))
               + sched[r-16];
    end
    a = hash_state[0]; b = hash_state[1]; c = hash_state[2]; d = hash_state[3];
    e = hash_state[4]; f = hash_state[5]; g = hash_state[6]; h = hash_state[7];
    for (int r = 0; r < 64; r++) begin
      t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
         + SHA_K[r] + sched[r];
      t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
      h = g; g = f; f = e; e = d + t1;
      d = c; c = b; b = a; a = t1 + t2;
    end
    hash_state[0] += a; hash_state[1] += b; hash_state[2] += c; hash_state[3] += d;
    hash_state[4] += e; hash_state[5] += f; hash_state[6] += g; hash_state[7] += h;
  endfunction

  function automatic void restart_hash();
    for (int i = 0; i < 8; i++) hash_state[i] = SHA_IV[i];
    blk_fill    = 0;
    hashed_bits = '0;
  endfunction

  // model one accepted request, queue the digest words it produces
  function automatic void hash_request(input byte_req_t req);
    int unsigned pos;
    logic [63:0] msg_bits;
    if (req.byte_present) begin
      blk_buf[blk_fill] = req.msg_byte;
      blk_fill++;
      if (blk_fill == 64) begin
        compress_buffer();
        hashed_bits += 64'd512;
        blk_fill = 0;
      end
    end
    if (!req.end_of_message) return;
    // padding, with an extra block when the length does not fit
    pos = blk_fill;
    msg_bits = hashed_bits + 64'(pos) * 64'd8;
    blk_buf[pos] = 8'h80;
    pos++;
    if (pos > 56) begin
      while (pos < 64) begin
        blk_buf[pos] = 8'h00;
        pos++;
      end
      compress_buffer();
      pos = 0;
    end
    while (pos < 56) begin
      blk_buf[pos] = 8'h00;
      pos++;
    end
    for (int i = 0; i < 8; i++) blk_buf[63-i] = msg_bits[8*i +: 8];
    compress_buffer();
    for (int i = 0; i < 8; i++) begin
      digest_queue.push_back('{digest_word: hash_state[i], word_number: 3'(i),
                               last_word: (i == 7)});
    end
    restart_hash();
  endfunction

  function automatic void note_fault(input string msg);
    if (fault_count < REPORT_MAX) $display("%s", msg);
    fault_count++;
  endfunction

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hff;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // queue one message, with the odd ignored request mixed in when with_noise is set
  function automatic int unsigned queue_message(input int unsigned len, input bit end_alone,
                                                input bit with_noise);
    byte_req_t req;
    for (int unsigned i = 0; i < len; i++) begin
      if (with_noise && $urandom_range(0, 9) == 0) begin
        byte_requests.push_back('{msg_byte: pick_byte(), byte_present: 1'b0,
                                  end_of_message: 1'b0});
      end
      req.msg_byte       = pick_byte();
      req.byte_present   = 1'b1;
      req.end_of_message = (i == len - 1) && !end_alone;
      byte_requests.push_back(req);
    end
    if (end_alone || len == 0) begin
      byte_requests.push_back('{msg_byte: pick_byte(), byte_present: 1'b0,
                                end_of_message: 1'b1});
    end
    return len + ((end_alone || len == 0) ? 1 : 0);
  endfunction

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // byte request driver: bursts with random gaps
  always @(posedge clk) begin
    if (rst) begin
      in_bus.valid <= 1'b0;
    end else begin
      if (in_bus.valid && in_bus.ready) begin
        hash_request(byte_requests.pop_front());
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 4) == 1 ? $urandom_range(20, 60)
                                                 : $urandom_range(1, 12);
          gap_left   = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 8);
        end
      end
      if (in_bus.valid && !in_bus.ready) begin
        // hold the request until taken
      end else if (gap_left > 0) begin
        gap_left--;
        in_bus.valid <= 1'b0;
      end else if (byte_requests.size() > 0) begin
        in_bus.valid          <= 1'b1;
        in_bus.msg_byte       <= byte_requests[0].msg_byte;
        in_bus.byte_present   <= byte_requests[0].byte_present;
        in_bus.end_of_message <= byte_requests[0].end_of_message;
      end else begin
        in_bus.valid <= 1'b0;
      end
    end
  end

  // long receiver hold-off once the first digest is through
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_done && words_taken >= 8) begin
      hold_left <= LONG_HOLD;
      hold_done <= 1'b1;
    end
  end

  // digest monitor and receiver stall pattern
  always @(posedge clk) begin
    if (rst) begin
      out_bus.ready <= 1'b0;
      words_taken   <= 0;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        words_taken <= words_taken + 1;
        if (digest_queue.size() == 0) begin
          note_fault($sformatf("unexpected digest word %h number %0d last %b",
                               out_bus.digest_word, out_bus.word_number, out_bus.last_word));
        end else if (out_bus.digest_word !== digest_queue[0].digest_word ||
                     out_bus.word_number !== digest_queue[0].word_number ||
                     out_bus.last_word !== digest_queue[0].last_word) begin
          note_fault($sformatf("digest mismatch: expected %h/%0d/%b, got %h/%0d/%b",
                               digest_queue[0].digest_word, digest_queue[0].word_number,
                               digest_queue[0].last_word, out_bus.digest_word,
                               out_bus.word_number, out_bus.last_word));
          void'(digest_queue.pop_front());
        end else begin
          void'(digest_queue.pop_front());
        end
      end
      if (hold_left > 0) begin
        out_bus.ready <= 1'b0;
      end else begin
        case ((cycle_count / 50) % 4)
          0: out_bus.ready <= 1'b1;
          1: out_bus.ready <= ($urandom_range(0, 1) == 1);
          2: out_bus.ready <= ($urandom_range(0, 3) == 0);
          default: out_bus.ready <= (cycle_count % 3 == 0);
        endcase
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("sha256_byte_stream_hasher test failed");
      $finish;
    end
  end

  // stimulus and end of run
  initial begin
    int unsigned items;
    int unsigned msgs;
    int unsigned len;
    int unsigned long_lens [2];
    long_lens = '{64, 56};
    rst                   = 1'b1;
    in_bus.valid          = 1'b0;
    in_bus.msg_byte       = 8'h00;
    in_bus.byte_present   = 1'b0;
    in_bus.end_of_message = 1'b0;
    out_bus.ready         = 1'b0;
    fault_count           = 0;
    cycle_count           = 0;
    burst_left            = 8;
    gap_left              = 0;
    for (int i = 0; i < 64; i++) blk_buf[i] = 8'h00;
    restart_hash();

    // directed: ignored requests, empty message, single bytes, "abc"
    byte_requests.push_back('{msg_byte: 8'h00, byte_present: 1'b0, end_of_message: 1'b0});
    byte_requests.push_back('{msg_byte: 8'h00, byte_present: 1'b0, end_of_message: 1'b1});
    byte_requests.push_back('{msg_byte: 8'h00, byte_present: 1'b1, end_of_message: 1'b1});
    byte_requests.push_back('{msg_byte: 8'hff, byte_present: 1'b1, end_of_message: 1'b0});
    byte_requests.push_back('{msg_byte: 8'hff, byte_present: 1'b0, end_of_message: 1'b0});
    byte_requests.push_back('{msg_byte: 8'ha5, byte_present: 1'b0, end_of_message: 1'b1});
    byte_requests.push_back('{msg_byte: 8'h61, byte_present: 1'b1, end_of_message: 1'b0});
    byte_requests.push_back('{msg_byte: 8'h62, byte_present: 1'b1, end_of_message: 1'b0});
    byte_requests.push_back('{msg_byte: 8'h63, byte_present: 1'b1, end_of_message: 1'b1});

    // one message of a whole block, one that needs the extra padding block,
    // then short random ones up to the request target
    items = $unsigned(byte_requests.size());
    msgs  = 0;
    while (items < ITEM_TARGET) begin
      if (msgs < 2) len = long_lens[msgs];
      else len = $urandom_range(0, 14);
      void'(queue_message(len, $urandom_range(0, 1) == 1, msgs >= 2));
      items = $unsigned(byte_requests.size());
      msgs++;
    end

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    while (byte_requests.size() != 0 || in_bus.valid) @(posedge clk);
    while (digest_queue.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (digest_queue.size() != 0) note_fault("digest words missing at end of run");

    if (fault_count == 0) begin
      $display("sha256_byte_stream_hasher test passed");
    end else begin
      $display("sha256_byte_stream_hasher test failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
sv/sha256h_pkg.sv
sv/sha256h_if.sv
sv/sha256h_ctrl.sv
sv/sha256h_dp.sv
sv/sha256_byte_stream_hasher.sv
test/sha256_byte_stream_hasher_tb.sv
